/* hdl/ffp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants of the two-resource first-fit packer.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int unsigned MAX_BINS_DEF = 64;

  localparam int unsigned CPU_W       = 8;
  localparam int unsigned MEM_W       = 10;
  localparam int unsigned TYPE_W      = 5;
  localparam int unsigned BIN_INDEX_W = 6;
  localparam int unsigned BINS_USE_W  = 7;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_CPU_CAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_CAP = 1'd1;

  localparam logic [CPU_W-1:0] CPU_CAP_RST = 8'd56;
  localparam logic [MEM_W-1:0] MEM_CAP_RST = 10'd128;

  typedef enum logic [0:0] {
    OP_PLACE = 1'b0,
    OP_CLEAR = 1'b1
  } ffp_op_e;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NO_BIN   = 2'd2,
    ST_CLEARED  = 2'd3
  } ffp_status_e;

  typedef struct packed {
    logic [0:0]        opcode;
    logic [TYPE_W-1:0] vm_type;
    logic [CPU_W-1:0]  vm_cpu;
    logic [MEM_W-1:0]  vm_mem;
  } ffp_req_t;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic                   opened_bin;
    logic [1:0]             status;
    logic [BINS_USE_W-1:0]  bins_in_use;
    logic [TYPE_W-1:0]      type_echo;
  } ffp_res_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [MEM_W-1:0] mem;
  } ffp_cap_t;

  typedef struct packed {
    logic              valid;
    logic              active;
    logic              opened;
    ffp_status_e       status;
    logic [TYPE_W-1:0] vm_type;
    logic [CPU_W-1:0]  cpu;
    logic [MEM_W-1:0]  mem;
  } ffp_tok_t;

endpackage

/* hdl/ffp_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_stream_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface ffp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/first_fit_two_resource_packer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_two_resource_packer_unit
// First-fit placement of CPU/memory requests into bins held in a cell chain.
//
//   channel   dir  payload                                         width
//   req_if    in   opcode, vm_type, vm_cpu, vm_mem                  24
//   res_if    out  bin_index, opened_bin, status, bins_in_use,      21
//                  type_echo
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                  12
//
// A request walks the chain of MAX_BINS cells, one cell a cycle while the
// chain is not held, and then lands in the result register; one request is in
// the chain at a time, so a new request is taken only once the last has loaded.
// Reset empties the chain and closes all bins; capacities return to 56 / 128.
// A full result register with res_if.ready low holds the chain once a request reaches its end.
// ----------------------------------------------------------------------------
module first_fit_two_resource_packer_unit import ffp_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ffp_stream_if.sink            req_if,
  ffp_stream_if.source          res_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);
  localparam logic [CNT_W-1:0] BinsFull = CNT_W'(MAX_BINS);

  ffp_cap_t         cap_q;
  logic [CNT_W-1:0] open_cnt_q, open_cnt_d;
  logic             busy_q;
  logic             out_valid_q;
  ffp_res_t         res_q;
  logic             adv;
  ffp_req_t         req;
  ffp_tok_t         tok_w [0:MAX_BINS];
  logic [IDX_W-1:0] idx_w [0:MAX_BINS];
  ffp_tok_t         tok_end;
  logic             accept, load;

  assign req     = req_if.payload;
  assign accept  = req_if.valid && !busy_q;
  assign tok_end = tok_w[MAX_BINS];
  assign adv     = !(tok_end.valid && out_valid_q && !res_if.ready);
  assign load    = tok_end.valid && adv;

  // entry token
  always_comb begin
    tok_w[0]         = '0;
    tok_w[0].valid   = accept;
    tok_w[0].vm_type = req.vm_type;
    tok_w[0].cpu     = req.vm_cpu;
    tok_w[0].mem     = req.vm_mem;
    if (req.opcode == OP_CLEAR) begin
      tok_w[0].status = ST_CLEARED;
    end else if ((req.vm_cpu > cap_q.cpu) || (req.vm_mem > cap_q.mem)) begin
      tok_w[0].status = ST_OVERSIZE;
    end else begin
      tok_w[0].active = 1'b1;
      tok_w[0].status = ST_NO_BIN;
    end
  end
  assign idx_w[0] = '0;

  for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
    ffp_cell #(
      .CELL_IDX (g),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cap_i      (cap_q),
      .open_cnt_i (open_cnt_q),
      .tok_i      (tok_w[g]),
      .idx_i      (idx_w[g]),
      .tok_o      (tok_w[g+1]),
      .idx_o      (idx_w[g+1])
    );
  end

  always_comb begin
    open_cnt_d = open_cnt_q;
    if (tok_end.status == ST_CLEARED) begin
      open_cnt_d = '0;
    end else if (tok_end.opened) begin
      open_cnt_d = open_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q.cpu   <= CPU_CAP_RST;
      cap_q.mem   <= MEM_CAP_RST;
      open_cnt_q  <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CPU_CAP: cap_q.cpu <= cfg_data_i[CPU_W-1:0];
          REG_MEM_CAP: cap_q.mem <= cfg_data_i[MEM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        open_cnt_q  <= open_cnt_d;
        out_valid_q <= 1'b1;
      end else if (res_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.bin_index   <= BIN_INDEX_W'(idx_w[MAX_BINS]);
      res_q.opened_bin  <= tok_end.opened;
      res_q.status      <= tok_end.status;
      res_q.bins_in_use <= BINS_USE_W'(open_cnt_d);
      res_q.type_echo   <= tok_end.vm_type;
    end
  end

  assign req_if.ready   = !busy_q;
  assign res_if.valid   = out_valid_q;
  assign res_if.payload = res_q;

  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !tok_end.valid)
    else $error("token at chain end while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_cnt_q <= BinsFull)
    else $error("open bin count beyond capacity");

  a_open_then_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && tok_end.opened |-> tok_end.status == ST_PLACED)
    else $error("bin opened without placement");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && tok_end.status == ST_CLEARED |=> open_cnt_q == '0)
    else $error("clear left bins open");

endmodule

/* hdl/ffp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffp_cell
// One bin of the packer chain: holds remaining CPU and memory, places a
// passing request if it fits or opens the bin, and hands the request on.
// ----------------------------------------------------------------------------
module ffp_cell import ffp_pkg::*; #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = BIN_INDEX_W,
  parameter int unsigned CNT_W    = BINS_USE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  ffp_cap_t         cap_i,
  input  logic [CNT_W-1:0] open_cnt_i,
  input  ffp_tok_t         tok_i,
  input  logic [IDX_W-1:0] idx_i,
  output ffp_tok_t         tok_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam logic [CNT_W-1:0] MyPos = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [CPU_W-1:0] cpu_left_q, cpu_left_d;
  logic [MEM_W-1:0] mem_left_q, mem_left_d;
  ffp_tok_t         tok_q, tok_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             take, hit, fresh;

  always_comb begin
    take  = tok_i.valid && tok_i.active;
    hit   = take && (MyPos < open_cnt_i) &&
            (cpu_left_q >= tok_i.cpu) && (mem_left_q >= tok_i.mem);
    fresh = take && (MyPos == open_cnt_i);

    tok_d      = tok_i;
    idx_d      = idx_i;
    cpu_left_d = cpu_left_q;
    mem_left_d = mem_left_q;

    if (hit) begin
      cpu_left_d   = cpu_left_q - tok_i.cpu;
      mem_left_d   = mem_left_q - tok_i.mem;
      tok_d.active = 1'b0;
      tok_d.status = ST_PLACED;
      idx_d        = MyIdx;
    end else if (fresh) begin
      cpu_left_d   = cap_i.cpu - tok_i.cpu;
      mem_left_d   = cap_i.mem - tok_i.mem;
      tok_d.active = 1'b0;
      tok_d.opened = 1'b1;
      tok_d.status = ST_PLACED;
      idx_d        = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q      <= idx_d;
      cpu_left_q <= cpu_left_d;
      mem_left_q <= mem_left_d;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

/* dv/first_fit_two_resource_packer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_two_resource_packer_unit_tb
// Self-checking bench for the two-resource first-fit packer. A table of
// directed requests covers the field extremes, clears, oversize requests and
// zero demand. Random phases follow, each at a fresh pair of bin capacities.
// Every request is predicted by a local bin model and each result is
// compared field by field. Both channels idle at random, and the result side
// is held off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module first_fit_two_resource_packer_unit_tb;
  import ffp_pkg::*;

  localparam int unsigned BINS        = MAX_BINS_DEF;
  localparam int unsigned ITEMS       = 1550;
  localparam int unsigned QUIET_ITEMS = 150;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned HOLD_AFTER  = 400;
  localparam int unsigned WATCHDOG    = 4000;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef struct {
    ffp_req_t req;
    bit       pinned;
    ffp_res_t res;
  } dir_entry_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ffp_stream_if #(.T(ffp_req_t)) req_bus ();
  ffp_stream_if #(.T(ffp_res_t)) res_bus ();

  first_fit_two_resource_packer_unit #(.MAX_BINS(BINS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_if     (req_bus),
    .res_if     (res_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // bin model
  logic [CPU_W-1:0] cpu_left_m [BINS];
  logic [MEM_W-1:0] mem_left_m [BINS];
  int unsigned      bins_open  = 0;
  logic [CPU_W-1:0] cap_cpu_m  = CPU_CAP_RST;
  logic [MEM_W-1:0] cap_mem_m  = MEM_CAP_RST;

  ffp_res_t    placements_due [$];
  dir_entry_t  dir_table [$];
  bit          pin_valid    = 1'b0;
  ffp_res_t    pin_res      = '0;
  bit          quiet        = 1'b0;
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void queue_result(ffp_res_t res);
    placements_due = {placements_due, res};
  endfunction

  function automatic void add_row(dir_entry_t e);
    dir_table = {dir_table, e};
  endfunction

  function automatic ffp_res_t place_or_clear(ffp_req_t r);
    ffp_res_t    res;
    int unsigned slot;
    bit          done;
    res           = '0;
    res.type_echo = r.vm_type;
    slot          = 0;
    done          = 1'b0;
    if (r.opcode == OP_CLEAR) begin
      bins_open  = 0;
      res.status = ST_CLEARED;
    end else if (r.vm_cpu > cap_cpu_m || r.vm_mem > cap_mem_m) begin
      res.status = ST_OVERSIZE;
    end else begin
      while (!done && slot < bins_open) begin
        if (cpu_left_m[slot] >= r.vm_cpu && mem_left_m[slot] >= r.vm_mem) begin
          cpu_left_m[slot] = cpu_left_m[slot] - r.vm_cpu;
          mem_left_m[slot] = mem_left_m[slot] - r.vm_mem;
          res.bin_index    = BIN_INDEX_W'(slot);
          res.status       = ST_PLACED;
          done             = 1'b1;
        end else begin
          slot++;
        end
      end
      if (!done) begin
        if (bins_open >= BINS) begin
          res.status = ST_NO_BIN;
        end else begin
          cpu_left_m[bins_open] = cap_cpu_m - r.vm_cpu;
          mem_left_m[bins_open] = cap_mem_m - r.vm_mem;
          res.bin_index         = BIN_INDEX_W'(bins_open);
          res.opened_bin        = 1'b1;
          res.status            = ST_PLACED;
          bins_open++;
        end
      end
    end
    res.bins_in_use = BINS_USE_W'(bins_open);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_placement(ffp_res_t got);
    ffp_res_t want;
    if (placements_due.size() == 0) begin
      report_mismatch($sformatf("result with no request pending: %p", got));
      return;
    end
    want = placements_due.pop_front();
    if (got.bin_index !== want.bin_index)
      report_mismatch($sformatf("bin_index %0d, want %0d", got.bin_index, want.bin_index));
    if (got.opened_bin !== want.opened_bin)
      report_mismatch($sformatf("opened_bin %0b, want %0b", got.opened_bin, want.opened_bin));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.bins_in_use !== want.bins_in_use)
      report_mismatch($sformatf("bins_in_use %0d, want %0d", got.bins_in_use,
                                want.bins_in_use));
    if (got.type_echo !== want.type_echo)
      report_mismatch($sformatf("type_echo %0d, want %0d", got.type_echo, want.type_echo));
  endtask

  always @(posedge clk_i) begin
    ffp_res_t want;
    bit       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        moved = 1'b1;
        if (cfg_idx_i == REG_CPU_CAP) cap_cpu_m = cfg_data_i[CPU_W-1:0];
        else cap_mem_m = cfg_data_i[MEM_W-1:0];
      end
      if (res_bus.valid && res_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        check_placement(res_bus.payload);
      end
      if (req_bus.valid && req_bus.ready) begin
        moved = 1'b1;
        want  = place_or_clear(req_bus.payload);
        queue_result(pin_valid ? pin_res : want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: short random stalls, one long hold while requests queue up
  initial begin
    int unsigned stall_left;
    bit          long_done;
    stall_left    = 0;
    long_done     = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!long_done && results_seen >= HOLD_AFTER && req_bus.valid) begin
        long_done     = 1'b1;
        stall_left    = LONG_HOLD - 1;
        res_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left    = $urandom_range(0, 2);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic put_request(ffp_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic set_capacity(int unsigned cpu, int unsigned mem);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CPU_CAP;
    cfg_data_i <= CFG_DATA_W'(cpu);
    @(negedge clk_i);
    cfg_idx_i  <= REG_MEM_CAP;
    cfg_data_i <= CFG_DATA_W'(mem);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_placements_done();
    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (placements_due.size() != 0);
  endtask

  function automatic dir_entry_t entry(ffp_op_e op, int unsigned ty, int unsigned cpu,
                                       int unsigned mem, bit pinned = 1'b0,
                                       int unsigned idx = 0, bit opened = 1'b0,
                                       ffp_status_e st = ST_PLACED,
                                       int unsigned in_use = 0);
    dir_entry_t e;
    e.req.opcode      = op;
    e.req.vm_type     = TYPE_W'(ty);
    e.req.vm_cpu      = CPU_W'(cpu);
    e.req.vm_mem      = MEM_W'(mem);
    e.pinned          = pinned;
    e.res.bin_index   = BIN_INDEX_W'(idx);
    e.res.opened_bin  = opened;
    e.res.status      = st;
    e.res.bins_in_use = BINS_USE_W'(in_use);
    e.res.type_echo   = TYPE_W'(ty);
    return e;
  endfunction

  initial begin
    ffp_req_t    r;
    int unsigned items_sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned gen_cpu;
    int unsigned gen_mem;
    int unsigned pick;
    int unsigned shift;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_CPU_CAP;
    cfg_data_i      = '0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    items_sent      = 0;

    // capacities at reset: 56 CPU, 128 GB
    add_row(entry(OP_CLEAR,  0,   0,    0, 1, 0, 0, ST_CLEARED,  0));
    add_row(entry(OP_PLACE,  1,   0,    0, 1, 0, 1, ST_PLACED,   1));
    add_row(entry(OP_PLACE, 31,  56,  128, 1, 0, 0, ST_PLACED,   1));
    add_row(entry(OP_PLACE,  2,  57,    0, 1, 0, 0, ST_OVERSIZE, 1));
    add_row(entry(OP_PLACE,  3,   0,  129, 1, 0, 0, ST_OVERSIZE, 1));
    add_row(entry(OP_PLACE,  4, 255, 1023, 1, 0, 0, ST_OVERSIZE, 1));
    add_row(entry(OP_PLACE,  5,   0,    0, 1, 0, 0, ST_PLACED,   1));
    add_row(entry(OP_PLACE,  6,   1,    1, 1, 1, 1, ST_PLACED,   2));
    add_row(entry(OP_PLACE,  7,  20,   64));
    add_row(entry(OP_PLACE,  8,  36,   10));
    add_row(entry(OP_PLACE,  9,  35,   63));
    add_row(entry(OP_PLACE, 10,  20,  100));
    add_row(entry(OP_PLACE, 11,   1,    0));
    add_row(entry(OP_PLACE, 12,   0,   18));
    add_row(entry(OP_PLACE, 13, 170,  682));
    add_row(entry(OP_PLACE, 21,  85,  341));
    add_row(entry(OP_CLEAR, 31, 255, 1023, 1, 0, 0, ST_CLEARED,  0));
    add_row(entry(OP_PLACE, 16,  56,  128, 1, 0, 1, ST_PLACED,   1));
    add_row(entry(OP_PLACE, 17,  56,    0));
    add_row(entry(OP_PLACE,  0,   0,    0));
    add_row(entry(OP_CLEAR, 10,   0,    0, 1, 0, 0, ST_CLEARED,  0));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_table[k]) begin
      pin_valid = dir_table[k].pinned;
      pin_res   = dir_table[k].res;
      put_request(dir_table[k].req);
      items_sent++;
    end
    pin_valid = 1'b0;

    phase = 0;
    while (items_sent < ITEMS) begin
      wait_placements_done();
      case (phase % 6)
        0: begin gen_cpu = 1;   gen_mem = 1;    end
        1: begin gen_cpu = 255; gen_mem = 1023; end
        2: begin gen_cpu = CPU_CAP_RST; gen_mem = MEM_CAP_RST; end
        3: begin gen_cpu = $urandom_range(1, 6);   gen_mem = $urandom_range(1, 12);   end
        4: begin gen_cpu = $urandom_range(1, 255); gen_mem = $urandom_range(1, 1023); end
        default: begin
          gen_cpu = $urandom_range(0, 1) ? 255 : 1;
          gen_mem = (gen_cpu == 1) ? 1023 : 1;
        end
      endcase
      set_capacity(gen_cpu, gen_mem);
      phase++;

      // keep bins open across some capacity changes
      if ($urandom_range(0, 1) == 0) begin
        r        = '0;
        r.opcode = OP_CLEAR;
        r.vm_type = TYPE_W'($urandom);
        put_request(r);
        items_sent++;
      end

      phase_len = $urandom_range(40, 120);
      if (phase_len > ITEMS - items_sent) phase_len = ITEMS - items_sent;
      repeat (phase_len) begin
        quiet     = (items_sent >= ITEMS - QUIET_ITEMS);
        pick      = $urandom_range(0, 99);
        r.opcode  = OP_PLACE;
        r.vm_type = TYPE_W'($urandom);
        r.vm_cpu  = CPU_W'($urandom);
        r.vm_mem  = MEM_W'($urandom);
        if (pick < 3) begin
          r.opcode = OP_CLEAR;
        end else if (pick < 10) begin
          // leave the random demand as it stands
        end else if (pick < 16 && (gen_cpu < 255 || gen_mem < 1023)) begin
          if (gen_cpu < 255 && (gen_mem == 1023 || $urandom_range(0, 1)))
            r.vm_cpu = CPU_W'($urandom_range(gen_cpu + 1, 255));
          else
            r.vm_mem = MEM_W'($urandom_range(gen_mem + 1, 1023));
        end else begin
          shift    = $urandom_range(0, 3);
          r.vm_cpu = CPU_W'($urandom_range(0, gen_cpu) >> shift);
          shift    = $urandom_range(0, 3);
          r.vm_mem = MEM_W'($urandom_range(0, gen_mem) >> shift);
        end
        put_request(r);
        items_sent++;
      end
    end

    wait_placements_done();
    repeat (2 * (BINS + 1)) @(negedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ffp_pkg.sv
hdl/ffp_stream_if.sv
hdl/ffp_cell.sv
hdl/first_fit_two_resource_packer_unit.sv
dv/first_fit_two_resource_packer_unit_tb.sv
